// ===== hdl/imh_pkg.sv =====
`default_nettype none
package imh_pkg;

    localparam int NODES_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 48;
    localparam int KEY_W          = 10;
    localparam int VAL_W          = 48;
    localparam int TOTAL_W        = 11;
    localparam int STAT_W         = 3;
    localparam int CMD_W          = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP      = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL_DUP  = 3'd3;
    localparam logic [STAT_W-1:0] ST_SATURATED = 3'd4;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_INS_WR,
        S_DEC_RD,
        S_DEC_WR,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_WR,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DN_PICK,
        S_SWAP_A,
        S_SWAP_B,
        S_FIN_RD,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_LOOKUP,
        OP_INS_WR,
        OP_RD_CUR,
        OP_DEC_WR,
        OP_RD_ROOT,
        OP_RD_LAST,
        OP_POP_WR,
        OP_RD_PARENT,
        OP_RD_CHILDREN,
        OP_PICK,
        OP_SWAP_A,
        OP_SWAP_B,
        OP_FIN_RD
    } t_op;

    typedef struct packed {
        t_op op;
        logic go_up;
        logic ovr_done;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic [CMD_W-1:0] cmd;
        logic ins_bad;
        logic dec_bad;
        logic empty;
        logic last_zero;
        logic up_stop;
        logic dn_stop;
        logic dn_two;
        logic child_swap;
    } t_status;

endpackage
`default_nettype wire

// ===== hdl/imh_ram.sv =====
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/imh_ctrl.sv =====
`default_nettype none
module imh_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  wire               i_m_ready,
    input  imh_pkg::t_status  i_st,
    output imh_pkg::t_cmd     o_cmd
);
    import imh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_st.clear_done) n_state = S_IDLE;
            S_IDLE:    if (i_s_valid) n_state = S_LOOKUP;
            S_LOOKUP:  n_state = S_DECIDE;
            S_DECIDE: begin
                unique case (i_st.cmd)
                    CMD_INSERT:   n_state = i_st.ins_bad ? S_FIN_RD : S_INS_WR;
                    CMD_DECREASE: n_state = i_st.dec_bad ? S_FIN_RD : S_DEC_RD;
                    CMD_POP:      n_state = i_st.empty ? S_FIN_RD : S_POP_RD0;
                    default:      n_state = S_FIN_RD;
                endcase
            end
            S_INS_WR:  n_state = S_UP_RD;
            S_DEC_RD:  n_state = S_DEC_WR;
            S_DEC_WR:  n_state = S_UP_RD;
            S_POP_RD0: n_state = S_POP_RDL;
            S_POP_RDL: n_state = S_POP_WR;
            S_POP_WR:  n_state = i_st.last_zero ? S_FIN_RD : S_DN_RD;
            S_UP_RD:   n_state = S_UP_CMP;
            S_UP_CMP:  n_state = i_st.up_stop ? S_FIN_RD : S_SWAP_A;
            S_DN_RD:   n_state = i_st.dn_stop ? S_FIN_RD : S_DN_CMP;
            S_DN_CMP:  n_state = S_DN_PICK;
            S_DN_PICK: n_state = i_st.child_swap ? S_SWAP_A : S_FIN_RD;
            S_SWAP_A:  n_state = S_SWAP_B;
            S_SWAP_B:  n_state = (i_st.cmd == CMD_POP) ? S_DN_RD : S_UP_RD;
            S_FIN_RD:  n_state = S_FIN;
            S_FIN:     n_state = S_OUT;
            S_OUT:     if (i_m_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        o_m_valid = 1'b0;
        unique case (r_state)
            S_CLEAR:   o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                o_s_ready = 1'b1;
                o_cmd.op  = OP_LOAD;
            end
            S_LOOKUP:  o_cmd.op = OP_LOOKUP;
            S_INS_WR:  o_cmd.op = OP_INS_WR;
            S_DEC_RD:  o_cmd.op = OP_RD_CUR;
            S_DEC_WR:  o_cmd.op = OP_DEC_WR;
            S_POP_RD0: o_cmd.op = OP_RD_ROOT;
            S_POP_RDL: o_cmd.op = OP_RD_LAST;
            S_POP_WR:  o_cmd.op = OP_POP_WR;
            S_UP_RD:   o_cmd.op = OP_RD_PARENT;
            S_DN_RD:   o_cmd.op = OP_RD_CHILDREN;
            S_DN_CMP:  o_cmd.op = OP_RD_CHILDREN;
            S_DN_PICK: o_cmd.op = OP_PICK;
            S_SWAP_A:  o_cmd.op = OP_SWAP_A;
            S_SWAP_B: begin
                o_cmd.op    = OP_SWAP_B;
                o_cmd.go_up = (i_st.cmd != CMD_POP);
            end
            S_FIN_RD:  o_cmd.op = OP_FIN_RD;
            S_OUT:     o_m_valid = 1'b1;
            default:   o_cmd.op = OP_NONE;
        endcase
        o_cmd.ovr_done = (r_state == S_DN_CMP);
    end
endmodule
`default_nettype wire

// ===== hdl/imh_dp.sv =====
`default_nettype none
module imh_dp #(
    parameter int NODES      = imh_pkg::NODES_DEF,
    parameter int VALUE_BITS = imh_pkg::VALUE_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  imh_pkg::t_cmd              i_cmd,
    output imh_pkg::t_status           o_st,
    input  wire [imh_pkg::CMD_W-1:0]   i_in_cmd,
    input  wire [imh_pkg::KEY_W-1:0]   i_in_key,
    input  wire [imh_pkg::VAL_W-1:0]   i_in_value,
    input  wire [imh_pkg::VAL_W-1:0]   i_in_delta,
    output logic [imh_pkg::KEY_W-1:0]  o_min_key,
    output logic [imh_pkg::VAL_W-1:0]  o_min_value,
    output logic [imh_pkg::STAT_W-1:0] o_status,
    output logic                       o_key_present,
    output logic [imh_pkg::TOTAL_W-1:0] o_entry_total
);
    import imh_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int KW = (AW > KEY_W) ? AW : KEY_W;
    localparam int EW = KW + VALUE_BITS;
    localparam int PW = CW + 1;

    // heap entry: {key, value}; position entry: {present, slot}
    logic          h_we;
    logic [AW-1:0] h_wa, h_ra;
    logic [EW-1:0] h_wd, h_rd;
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra;
    logic [PW-1:0] p_wd, p_rd;

    imh_ram #(.WIDTH(EW), .DEPTH(NODES)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );
    imh_ram #(.WIDTH(PW), .DEPTH(NODES)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd)
    );

    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_val, r_delta;
    logic                  r_key_ok;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_clr;
    logic                  r_clr_done;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [EW-1:0]         r_ei, r_ej, r_ec;
    logic [PW-1:0]         r_pos;
    logic [STAT_W-1:0]     r_status;
    logic [KEY_W-1:0]      r_min_key;
    logic [VAL_W-1:0]      r_min_val;
    logic                  r_present;
    logic                  r_cap_par, r_cap_fin;

    logic [AW-1:0]         k_addr;
    logic [CW:0]           c_left;
    logic [CW-1:0]         c_par;
    logic [VALUE_BITS-1:0] v_i, v_c, v_r;
    logic [VALUE_BITS:0]   dec_diff;
    logic [VALUE_BITS-1:0] dec_val;
    logic                  right_sel;

    assign k_addr    = AW'(r_key);
    assign c_left    = {r_i, 1'b1};
    assign c_par     = (r_i - CW'(1)) >> 1;
    assign v_i       = r_ei[VALUE_BITS-1:0];
    assign v_c       = r_ec[VALUE_BITS-1:0];
    assign v_r       = h_rd[VALUE_BITS-1:0];
    assign dec_diff  = {1'b0, h_rd[VALUE_BITS-1:0]} - {1'b0, r_delta};
    assign dec_val   = dec_diff[VALUE_BITS] ? '0 : dec_diff[VALUE_BITS-1:0];
    // right child wins only when present and strictly smaller
    assign right_sel = ((c_left + 1'b1) < {1'b0, r_count}) && (v_r < v_c);

    always_comb begin
        o_st            = '0;
        o_st.clear_done = r_clr_done;
        o_st.cmd        = r_cmd;
        o_st.ins_bad    = !r_key_ok || p_rd[CW] || (r_count >= CW'(NODES));
        o_st.dec_bad    = !r_key_ok || !p_rd[CW] || (p_rd[CW-1:0] >= r_count);
        o_st.empty      = (r_count == '0);
        o_st.last_zero  = (r_count == '0);
        o_st.up_stop    = (r_i == '0) || !(v_r > v_i);
        o_st.dn_stop    = (c_left >= {1'b0, r_count});
        o_st.child_swap = ((right_sel ? v_r : v_c) < v_i);
    end

    always_comb begin
        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = k_addr;
        case (i_cmd.op)
            OP_CLEAR: begin
                p_we = 1'b1; p_wa = r_clr; p_wd = '0;
            end
            OP_LOAD:   p_ra = AW'(i_in_key);
            OP_INS_WR: begin
                h_we = 1'b1; h_wa = AW'(r_count); h_wd = {KW'(r_key), r_val};
                p_we = 1'b1; p_wa = k_addr; p_wd = {1'b1, r_count};
            end
            OP_RD_CUR: h_ra = AW'(r_pos[CW-1:0]);
            OP_DEC_WR: begin
                h_we = 1'b1; h_wa = AW'(r_i);
                h_wd = {h_rd[EW-1:VALUE_BITS], dec_val};
            end
            OP_RD_ROOT: h_ra = '0;
            OP_RD_LAST: begin
                h_ra = AW'(r_count - CW'(1));
                p_we = 1'b1; p_wa = AW'(h_rd[EW-1:VALUE_BITS]); p_wd = '0;
            end
            OP_POP_WR: begin
                if (r_count != '0) begin
                    h_we = 1'b1; h_wa = '0; h_wd = h_rd;
                    p_we = 1'b1; p_wa = AW'(h_rd[EW-1:VALUE_BITS]); p_wd = {1'b1, CW'(0)};
                end
            end
            OP_RD_PARENT: h_ra = AW'(c_par);
            OP_RD_CHILDREN: h_ra = i_cmd.ovr_done ? AW'(c_left + 1'b1) : AW'(c_left);
            OP_SWAP_A: begin
                h_we = 1'b1; h_wa = AW'(r_i); h_wd = r_ej;
                p_we = 1'b1; p_wa = AW'(r_ej[EW-1:VALUE_BITS]); p_wd = {1'b1, r_i};
            end
            OP_SWAP_B: begin
                h_we = 1'b1; h_wa = AW'(r_j); h_wd = r_ei;
                p_we = 1'b1; p_wa = AW'(r_ei[EW-1:VALUE_BITS]); p_wd = {1'b1, r_j};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_count    <= '0;
            r_cap_par  <= 1'b0;
            r_cap_fin  <= 1'b0;
        end else begin
            r_cap_par <= (i_cmd.op == OP_RD_PARENT);
            r_cap_fin <= (i_cmd.op == OP_FIN_RD);
            if (r_cap_par) r_ej <= h_rd;
            if (r_cap_fin) r_present <= r_key_ok && p_rd[CW];
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NODES - 1)) r_clr_done <= 1'b1;
                end
                OP_LOAD: begin
                    r_cmd    <= i_in_cmd;
                    r_key    <= i_in_key;
                    r_val    <= VALUE_BITS'(i_in_value);
                    r_delta  <= VALUE_BITS'(i_in_delta);
                    r_key_ok <= ({1'b0, i_in_key} < (KEY_W + 1)'(NODES)) || (NODES > 1024);
                    r_status <= ST_OK;
                    r_min_key <= '0;
                    r_min_val <= '0;
                end
                OP_LOOKUP: begin
                    r_pos <= p_rd;
                    if (r_cmd == CMD_INSERT && (!r_key_ok || p_rd[CW] || r_count >= CW'(NODES)))
                        r_status <= ST_FULL_DUP;
                    if (r_cmd == CMD_DECREASE &&
                        (!r_key_ok || !p_rd[CW] || p_rd[CW-1:0] >= r_count))
                        r_status <= ST_ABSENT;
                    if (r_cmd == CMD_POP && r_count == '0)
                        r_status <= ST_EMPTY;
                end
                OP_INS_WR: begin
                    r_count <= r_count + 1'b1;
                    r_i     <= r_count;
                    r_ei    <= {KW'(r_key), r_val};
                end
                OP_RD_CUR: r_i <= r_pos[CW-1:0];
                OP_DEC_WR: begin
                    r_ei <= {h_rd[EW-1:VALUE_BITS], dec_val};
                    if (dec_diff[VALUE_BITS]) r_status <= ST_SATURATED;
                end
                OP_RD_LAST: begin
                    r_ei      <= h_rd;
                    r_min_key <= KEY_W'(h_rd[EW-1:VALUE_BITS]);
                    r_min_val <= VAL_W'(h_rd[VALUE_BITS-1:0]);
                    r_count   <= r_count - 1'b1;
                end
                OP_POP_WR: begin
                    r_ei <= h_rd;
                    r_i  <= '0;
                end
                OP_RD_PARENT: r_j <= c_par;
                OP_RD_CHILDREN: begin
                    if (i_cmd.ovr_done) begin
                        r_ec <= h_rd;
                        r_j  <= CW'(c_left);
                    end
                end
                OP_PICK: begin
                    if (right_sel) begin
                        r_ej <= h_rd;
                        r_j  <= CW'(c_left + 1'b1);
                    end else begin
                        r_ej <= r_ec;
                    end
                end
                OP_SWAP_B: r_i <= r_j;
                default: ;
            endcase
        end
    end

    assign o_min_key     = r_min_key;
    assign o_min_value   = r_min_val;
    assign o_status      = r_status;
    assign o_key_present = r_present;
    assign o_entry_total = TOTAL_W'(r_count);
endmodule
`default_nettype wire

// ===== hdl/indexed_min_heap_decrease_key.sv =====
`default_nettype none
// Processing: a rejected or unknown command goes straight to the result; insert and
// decrease sift the entry up one level at a time, and pop moves the last entry to the
// root and sifts it down, or finishes at once when the heap empties.
// Throughput: one item at a time, next accept the cycle after the result handshake;
// the heap RAM's single read port sets the pace.
// Reset: synchronous active-low; afterwards a clearing pass sweeps the position map
// while the input is held off.
module indexed_min_heap_decrease_key #(
    parameter int NODES      = imh_pkg::NODES_DEF,
    parameter int VALUE_BITS = imh_pkg::VALUE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [111:0] s_axis_tdata,  // cmd[1:0], key[11:2], value[59:12], delta[107:60]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata    // min_key, min_value, status, key_present, entry_total
);
    import imh_pkg::*;

    t_cmd    cmd;
    t_status st;

    imh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .o_s_ready(s_axis_tready),
        .o_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_st(st), .o_cmd(cmd)
    );

    logic [KEY_W-1:0]   min_key;
    logic [VAL_W-1:0]   min_value;
    logic [STAT_W-1:0]  status;
    logic               key_present;
    logic [TOTAL_W-1:0] entry_total;

    imh_dp #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_st(st),
        .i_in_cmd(s_axis_tdata[1:0]), .i_in_key(s_axis_tdata[11:2]),
        .i_in_value(s_axis_tdata[59:12]), .i_in_delta(s_axis_tdata[107:60]),
        .o_min_key(min_key), .o_min_value(min_value), .o_status(status),
        .o_key_present(key_present), .o_entry_total(entry_total)
    );

    assign m_axis_tdata = {7'd0, entry_total, key_present, status, min_value, min_key};
endmodule
`default_nettype wire

// ===== test/indexed_min_heap_decrease_key_tb.sv =====
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_tb;
    import imh_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [VAL_W-1:0]  delta;
    } heap_op_t;

    // highest field first, so min_key sits in the low bits as on the bus
    typedef struct packed {
        logic [TOTAL_W-1:0] entry_total;
        logic               key_present;
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   min_value;
        logic [KEY_W-1:0]   min_key;
    } heap_resp_t;

    localparam int N = NODES_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [111:0]  s_axis_tdata;   // cmd, key, value, delta
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [79:0]   m_axis_tdata;   // min_key, min_value, status, key_present, entry_total

    indexed_min_heap_decrease_key dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    heap_op_t   pending_ops[$];
    heap_resp_t expected_resps[$];
    heap_op_t   cur_op;
    int         send_gap;
    int         recv_gap;
    int         errors = 0;
    int         idle_cycles;
    bit         quiet = 1'b0;

    logic [KEY_W-1:0] hkey[N];
    logic [VAL_W-1:0] hval[N];
    int               hpos[N];
    int               hcount;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        if (quiet) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        k = hkey[a]; v = hval[a];
        hkey[a] = hkey[b]; hval[a] = hval[b];
        hkey[b] = k; hval[b] = v;
        hpos[hkey[a]] = a;
        hpos[hkey[b]] = b;
    endfunction

    function automatic void sift_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (hval[p] > hval[i]) begin
                swap_slots(i, p);
                i = p;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sift_down();
        int i;
        int c;
        i = 0;
        forever begin
            c = 2 * i + 1;
            if (c >= hcount) break;
            if (c + 1 < hcount && hval[c+1] < hval[c]) c = c + 1;
            if (hval[c] < hval[i]) begin
                swap_slots(i, c);
                i = c;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void predict_heap(heap_op_t op);
        heap_resp_t r;
        int slot;
        r = '0;
        r.status = ST_OK;
        case (op.cmd)
            CMD_INSERT: begin
                if (hpos[op.key] >= 0 || hcount >= N) begin
                    r.status = ST_FULL_DUP;
                end else begin
                    slot = hcount;
                    hkey[slot] = op.key;
                    hval[slot] = op.value;
                    hpos[op.key] = slot;
                    hcount++;
                    sift_up(slot);
                end
            end
            CMD_DECREASE: begin
                if (hpos[op.key] < 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    slot = hpos[op.key];
                    if (op.delta > hval[slot]) begin
                        hval[slot] = '0;
                        r.status = ST_SATURATED;
                    end else begin
                        hval[slot] = hval[slot] - op.delta;
                    end
                    sift_up(slot);
                end
            end
            CMD_POP: begin
                if (hcount == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.min_key = hkey[0];
                    r.min_value = hval[0];
                    hpos[hkey[0]] = -1;
                    hcount--;
                    if (hcount > 0) begin
                        hkey[0] = hkey[hcount];
                        hval[0] = hval[hcount];
                        hpos[hkey[0]] = 0;
                        sift_down();
                    end
                end
            end
            default: ;
        endcase
        r.key_present = hpos[op.key] >= 0;
        r.entry_total = hcount[TOTAL_W-1:0];
        expected_resps.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic heap_op_t mk(logic [1:0] c, logic [9:0] k,
                                    logic [47:0] v, logic [47:0] d);
        heap_op_t o;
        o.cmd = c; o.key = k; o.value = v; o.delta = d;
        return o;
    endfunction

    function automatic logic [47:0] rand_val();
        case ($urandom_range(0, 3))
            0: return 48'($urandom_range(0, 15));
            1: return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(0, 100000));
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
            hcount = 0;
            for (int i = 0; i < N; i++) hpos[i] = -1;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_heap(cur_op);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    cur_op = pending_ops.pop_front();
                    s_axis_tdata <= {4'b0, cur_op.delta, cur_op.value, cur_op.key, cur_op.cmd};
                    s_axis_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        heap_resp_t got;
        heap_resp_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[72:0];
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected item", 64'(got), 64'd0);
                end else begin
                    want = expected_resps.pop_front();
                    if (got.min_key !== want.min_key)
                        report_mismatch("min_key", 64'(got.min_key), 64'(want.min_key));
                    if (got.min_value !== want.min_value)
                        report_mismatch("min_value", 64'(got.min_value), 64'(want.min_value));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.key_present !== want.key_present)
                        report_mismatch("key_present", 64'(got.key_present),
                                        64'(want.key_present));
                    if (got.entry_total !== want.entry_total)
                        report_mismatch("entry_total", 64'(got.entry_total),
                                        64'(want.entry_total));
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("indexed_min_heap_decrease_key_tb: errors");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    end

    initial begin
        int r;
        logic [1:0] c;
        i_rst_n = 1'b0;

        pending_ops.push_back(mk(CMD_POP, 10'd5, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        pending_ops.push_back(mk(CMD_DECREASE, 10'd7, 48'd0, 48'd1));
        pending_ops.push_back(mk(CMD_INSERT, 10'd0, 48'hFFFF_FFFF_FFFF, 48'd0));
        pending_ops.push_back(mk(CMD_POP, 10'd0, 48'd0, 48'd0));
        pending_ops.push_back(mk(CMD_INSERT, 10'd1023, 48'd0, 48'hFFFF_FFFF_FFFF));
        pending_ops.push_back(mk(CMD_INSERT, 10'd1023, 48'd9, 48'd0));
        pending_ops.push_back(mk(CMD_INSERT, 10'd3, 48'd100, 48'd0));
        pending_ops.push_back(mk(CMD_INSERT, 10'd4, 48'd100, 48'd0));
        pending_ops.push_back(mk(CMD_INSERT, 10'd5, 48'd50, 48'd0));
        pending_ops.push_back(mk(CMD_DECREASE, 10'd4, 48'd0, 48'd50));
        pending_ops.push_back(mk(CMD_DECREASE, 10'd3, 48'd0, 48'd100));
        pending_ops.push_back(mk(CMD_DECREASE, 10'd5, 48'd0, 48'hFFFF_FFFF_FFFF));
        pending_ops.push_back(mk(CMD_DECREASE, 10'd9, 48'd0, 48'd1));
        pending_ops.push_back(mk(CMD_UNUSED, 10'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        for (int i = 0; i < 6; i++) pending_ops.push_back(mk(CMD_POP, 10'd3, 48'd0, 48'd0));

        for (int i = 0; i < 700; i++) begin
            r = $urandom_range(0, 99);
            c = r < 45 ? CMD_INSERT : r < 75 ? CMD_DECREASE : r < 97 ? CMD_POP : CMD_UNUSED;
            pending_ops.push_back(mk(c,
                $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, 47)),
                rand_val(), rand_val()));
        end

        for (int i = 0; i < 30; i++) begin
            c = $urandom_range(0, 1) ? CMD_POP : CMD_DECREASE;
            pending_ops.push_back(mk(c, 10'($urandom_range(0, 1023)), rand_val(), rand_val()));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid || expected_resps.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && !m_axis_tvalid) begin
            $display("indexed_min_heap_decrease_key_tb: clean");
        end else begin
            $display("indexed_min_heap_decrease_key_tb: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/imh_pkg.sv
hdl/imh_ram.sv
hdl/imh_ctrl.sv
hdl/imh_dp.sv
hdl/indexed_min_heap_decrease_key.sv
test/indexed_min_heap_decrease_key_tb.sv
